[design/usm_pkg.sv]
package usm_pkg;

  localparam int CordicSteps = 24;
  localparam logic [31:0] CordicGain = 32'd652032874;
  // positions and radius: signed/unsigned fixed point with this many fraction bits
  localparam int CoordFracBits = 8;

  typedef enum logic [2:0] {
    PH_NORTH  = 3'd0,
    PH_RING   = 3'd1,
    PH_SOUTH  = 3'd2,
    PH_TOP    = 3'd3,
    PH_BAND   = 3'd4,
    PH_BOTTOM = 3'd5,
    PH_DONE   = 3'd6
  } phase_e;

  localparam logic [1:0] REG_ROWS   = 2'd0;
  localparam logic [1:0] REG_COLS   = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  function automatic logic [31:0] atan_turn(input logic [4:0] k);
    logic [31:0] v;
    case (k)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

[design/usm_cordic.sv]
// Rotation CORDIC, one micro-rotation per cycle. Angle is a full-turn fraction.
module usm_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        angle_i,
  output logic               done_o,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);

  logic signed [33:0] x_q, x_d, y_q, y_d;
  logic signed [34:0] z_q, z_d;
  logic [1:0]  quad_q, quad_d;
  logic [4:0]  step_q, step_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic signed [33:0] dx, dy;
  logic signed [34:0] at;

  always_comb begin
    dx = y_q >>> step_q;
    dy = x_q >>> step_q;
    at = $signed({3'b000, usm_pkg::atan_turn(step_q)});
    x_d = x_q; y_d = y_q; z_d = z_q; quad_d = quad_q;
    step_d = step_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      x_d = $signed({2'b00, usm_pkg::CordicGain});
      y_d = '0;
      z_d = $signed({5'b00000, angle_i[29:0]});
      quad_d = angle_i[31:30];
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!z_q[34]) begin
        x_d = x_q - dx; y_d = y_q + dy; z_d = z_q - at;
      end else begin
        x_d = x_q + dx; y_d = y_q - dy; z_d = z_q + at;
      end
      step_d = step_q + 5'd1;
      if (step_q == 5'(usm_pkg::CordicSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d; quad_q <= quad_d;
  end

  always_comb begin
    case (quad_q)
      2'd0: begin cos_o = x_q;  sin_o = y_q;  end
      2'd1: begin cos_o = -y_q; sin_o = x_q;  end
      2'd2: begin cos_o = -x_q; sin_o = -y_q; end
      default: begin cos_o = y_q; sin_o = -x_q; end
    endcase
  end
  assign done_o = done_q;

endmodule

[design/usm_divider.sv]
// Restoring divider, one quotient bit per cycle.
module usm_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [40:0] num_i,
  input  logic [8:0]  den_i,
  output logic        done_o,
  output logic [40:0] quo_o
);

  logic [40:0] quo_q, quo_d;
  logic [9:0]  rem_q, rem_d;
  logic [8:0]  den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [9:0]  trial;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q[8:0], quo_q[40]};
    if (start_i) begin
      quo_d = num_i; rem_d = '0; den_d = den_i; cnt_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[39:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[39:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd40) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[design/uv_sphere_mesh_generator.sv]
// UV sphere mesh generator. Each accepted request emits one mesh item: north
// pole, (rows-1) rings of cols vertices, south pole, then the top cap, band and
// bottom cap triangles; the final triangle carries last. Triangles and poles
// go from the request through the S_OUT state to the result. A ring vertex
// runs through one shared serial divider (two angles and two shades), one
// shared 24-step CORDIC used twice, and one shared multiplier used four
// times. One request is in flight at a time; no new request is taken until
// the pending result has been accepted. A request after the last triangle
// returns nothing.
module uv_sphere_mesh_generator #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        restart_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        item_kind_o,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic signed [15:0] pos_z_o,
  output logic [15:0] shade_r_o,
  output logic [15:0] shade_g_o,
  output logic [11:0] corner_a_o,
  output logic [11:0] corner_b_o,
  output logic [11:0] corner_c_o,
  output logic        last_o
);

  localparam logic [8:0] MaxR = 9'(MAX_ROWS);
  localparam logic [8:0] MaxC = 9'(MAX_COLS);
  // CORDIC outputs are Q4.30; sin*radius keeps 16 extra fraction bits
  localparam int AngFrac = 30;
  localparam int MiniFrac = usm_pkg::CoordFracBits + 16;

  typedef enum logic [3:0] {
    S_IDLE, S_DIVA, S_DIVB, S_DIVR, S_DIVG, S_CORA, S_CORB,
    S_MULM, S_MULY, S_MULX, S_MULZ, S_OUT
  } seq_e;

  seq_e seq_q;
  logic [6:0]  row_cnt_q, col_cnt_q;
  logic [14:0] radius_q;
  usm_pkg::phase_e phase_q;
  logic [8:0]  row_q, col_q, rows_q, cols_q;
  logic        half_q;

  logic [6:0]  row_reg_q, col_reg_q;
  logic        busy_q;

  logic [31:0] pa_q, pb_q;
  logic signed [33:0] ca_q, sa_q, cb_q, sb_q;
  logic signed [47:0] mini_q;

  logic        ov_q, kind_q, last_q;
  logic signed [15:0] px_q, py_q, pz_q;
  logic [15:0] or_q, og_q;
  logic [11:0] a_q, b_q, c_q;

  // effective clamped sizes
  logic [8:0] eff_r, eff_c;
  always_comb begin
    eff_r = {2'b00, row_reg_q};
    if (eff_r < 9'd2) eff_r = 9'd2;
    if (eff_r > MaxR) eff_r = MaxR;
    eff_c = {2'b00, col_reg_q};
    if (eff_c < 9'd3) eff_c = 9'd3;
    if (eff_c > MaxC) eff_c = MaxC;
  end

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_reg_q <= 7'd16; col_reg_q <= 7'd16; radius_q <= 15'd256;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        usm_pkg::REG_ROWS:   row_reg_q <= cfg_data_i[6:0];
        usm_pkg::REG_COLS:   col_reg_q <= cfg_data_i[6:0];
        usm_pkg::REG_RADIUS: radius_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // shared divider
  logic        div_start, div_done;
  logic [40:0] div_num, div_quo;
  logic [8:0]  div_den;
  usm_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  // shared CORDIC
  logic        cor_start, cor_done;
  logic [31:0] cor_ang;
  logic signed [33:0] cor_cos, cor_sin;
  usm_cordic u_cor (
    .clk_i, .rst_ni, .start_i(cor_start), .angle_i(cor_ang),
    .done_o(cor_done), .cos_o(cor_cos), .sin_o(cor_sin)
  );

  // shared multiplier: 34 x 34 signed, combinational; each step registers its result
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic        started_q;
  logic signed [68:0] rnd;
  logic signed [68:0] shifted;
  logic [6:0]  rsh;
  always_comb begin
    mul_a = '0; mul_b = '0; rsh = 7'(AngFrac);
    case (seq_q)
      S_MULM: begin
        mul_a = sa_q; mul_b = $signed({19'd0, radius_q});
        rsh = 7'(AngFrac + usm_pkg::CoordFracBits - MiniFrac);
      end
      S_MULY: begin mul_a = ca_q; mul_b = $signed({19'd0, radius_q}); rsh = 7'(AngFrac); end
      S_MULX: begin
        mul_a = cb_q; mul_b = 34'(mini_q);
        rsh = 7'(AngFrac + MiniFrac - usm_pkg::CoordFracBits);
      end
      S_MULZ: begin
        mul_a = sb_q; mul_b = 34'(mini_q);
        rsh = 7'(AngFrac + MiniFrac - usm_pkg::CoordFracBits);
      end
      default: ;
    endcase
    rnd = 69'(mul_p) + (69'sd1 <<< (rsh - 7'd1));
    shifted = rnd >>> rsh;
  end

  function automatic logic signed [15:0] sat16(input logic signed [68:0] v);
    if (v > 69'sd32767) return 16'sd32767;
    if (v < -69'sd32768) return -16'sd32768;
    return 16'(v);
  endfunction

  // step controls
  always_comb begin
    div_start = 1'b0; div_num = '0; div_den = '0;
    cor_start = 1'b0; cor_ang = '0;
    if (!started_q) begin
      case (seq_q)
        S_DIVA: begin div_start = 1'b1;
          div_num = ((41'(row_q) + 41'd1) << 32) + 41'(rows_q);
          div_den = 9'(rows_q << 1); end
        S_DIVB: begin div_start = 1'b1;
          div_num = (41'(col_q) << 33) + 41'(cols_q); div_den = 9'(cols_q << 1); end
        S_DIVR: begin div_start = 1'b1;
          div_num = (41'(row_q) << 16) + 41'(rows_q); div_den = 9'(rows_q << 1); end
        S_DIVG: begin div_start = 1'b1;
          div_num = (41'(col_q) << 16) + 41'(cols_q); div_den = 9'(cols_q << 1); end
        S_CORA: begin cor_start = 1'b1; cor_ang = pa_q; end
        S_CORB: begin cor_start = 1'b1; cor_ang = pb_q; end
        default: ;
      endcase
    end
  end

  assign in_ready_o = !busy_q;
  logic acc;
  assign acc = in_valid_i && in_ready_o;

  // next position of the item walk (all item kinds) and the ring-vertex step sequence
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [8:0] i, j, r, c;
    logic [11:0] up, dn;
    logic vk, vl, vbusy;
    logic signed [15:0] vy;
    logic [15:0] vsh;
    logic [11:0] va, vb, vc;
    if (!rst_ni) begin
      seq_q <= S_IDLE; busy_q <= 1'b0; ov_q <= 1'b0; started_q <= 1'b0;
      phase_q <= usm_pkg::PH_NORTH; row_cnt_q <= '0; col_cnt_q <= '0; half_q <= 1'b0;
      row_q <= '0; col_q <= '0; rows_q <= 9'd16; cols_q <= 9'd16;
    end else begin
      if (ov_q && out_ready_i) begin
        ov_q <= 1'b0; busy_q <= 1'b0;
      end
      case (seq_q)
        S_IDLE: if (acc) begin
          r = eff_r; c = eff_c;
          i = restart_i ? 9'd0 : {2'b00, row_cnt_q};
          j = restart_i ? 9'd0 : {2'b00, col_cnt_q};
          rows_q <= r; cols_q <= c; row_q <= i; col_q <= j;
          vbusy = 1'b1; vk = 1'b1; vy = '0; vsh = '0;
          va = '0; vb = '0; vc = '0; vl = 1'b0;
          up = 12'(i * c); dn = 12'((i + 9'd1) * c);
          case (restart_i ? usm_pkg::PH_NORTH : phase_q)
            usm_pkg::PH_NORTH: begin
              vk = 1'b0; vy = $signed({1'b0, radius_q}); vsh = 16'h8000;
              phase_q <= usm_pkg::PH_RING; row_cnt_q <= '0; col_cnt_q <= '0;
              half_q <= restart_i ? 1'b0 : half_q;
              seq_q <= S_OUT;
            end
            usm_pkg::PH_RING: begin
              vk = 1'b0; seq_q <= S_DIVA;
              if (j + 9'd1 >= c) begin
                col_cnt_q <= '0; row_cnt_q <= 7'(i + 9'd1);
                if (i + 9'd1 >= r - 9'd1) phase_q <= usm_pkg::PH_SOUTH;
              end else col_cnt_q <= 7'(j + 9'd1);
            end
            usm_pkg::PH_SOUTH: begin
              vk = 1'b0; vy = -$signed({1'b0, radius_q}); vsh = 16'h8000;
              phase_q <= usm_pkg::PH_TOP; row_cnt_q <= '0; col_cnt_q <= '0; half_q <= 1'b0;
              seq_q <= S_OUT;
            end
            usm_pkg::PH_TOP: begin
              seq_q <= S_OUT;
              if (j >= c - 9'd1) begin
                va = '0; vb = 12'd1; vc = 12'(c);
                phase_q <= (r > 9'd2) ? usm_pkg::PH_BAND : usm_pkg::PH_BOTTOM;
                row_cnt_q <= '0; col_cnt_q <= '0; half_q <= 1'b0;
              end else begin
                va = '0; vb = 12'(j + 9'd2); vc = 12'(j + 9'd1);
                col_cnt_q <= 7'(j + 9'd1);
              end
            end
            usm_pkg::PH_BAND: begin
              seq_q <= S_OUT;
              if (j >= c - 9'd1) begin
                if (!half_q) begin
                  va = up + 12'd1; vb = dn + 12'd1; vc = dn;
                end else begin
                  va = dn + 12'd1; vb = 12'((i + 9'd2) * c); vc = dn;
                end
              end else if (!half_q) begin
                va = up + 12'(j) + 12'd1; vb = dn + 12'(j) + 12'd1;
                vc = dn + 12'(j) + 12'd2;
              end else begin
                va = up + 12'(j) + 12'd1; vb = dn + 12'(j) + 12'd2;
                vc = up + 12'(j) + 12'd2;
              end
              half_q <= !half_q;
              if (half_q) begin
                if (j + 9'd1 >= c) begin
                  col_cnt_q <= '0;
                  if (i + 9'd1 >= r - 9'd2) begin
                    phase_q <= usm_pkg::PH_BOTTOM; row_cnt_q <= '0;
                  end else row_cnt_q <= 7'(i + 9'd1);
                end else col_cnt_q <= 7'(j + 9'd1);
              end
            end
            usm_pkg::PH_BOTTOM: begin
              seq_q <= S_OUT;
              up = 12'((r - 9'd2) * c);
              dn = 12'((r - 9'd1) * c);
              if (j >= c - 9'd1) begin
                va = dn; vb = dn + 12'd1; vc = up + 12'd1; vl = 1'b1;
                phase_q <= usm_pkg::PH_DONE; col_cnt_q <= '0;
              end else begin
                va = up + 12'(j) + 12'd1; vb = dn + 12'd1; vc = up + 12'(j) + 12'd2;
                col_cnt_q <= 7'(j + 9'd1);
              end
            end
            default: begin
              vbusy = 1'b0;
              seq_q <= S_IDLE;
            end
          endcase
          busy_q <= vbusy;
          kind_q <= vk; px_q <= '0; py_q <= vy; pz_q <= '0;
          or_q <= vsh; og_q <= vsh;
          a_q <= va; b_q <= vb; c_q <= vc; last_q <= vl;
        end
        S_DIVA, S_DIVB, S_DIVR, S_DIVG: begin
          started_q <= !div_done;
          if (div_done) begin
            case (seq_q)
              S_DIVA: begin pa_q <= div_quo[31:0]; seq_q <= S_DIVB; end
              S_DIVB: begin pb_q <= div_quo[31:0]; seq_q <= S_DIVR; end
              S_DIVR: begin or_q <= div_quo[15:0]; seq_q <= S_DIVG; end
              default: begin og_q <= div_quo[15:0]; seq_q <= S_CORA; end
            endcase
          end
        end
        S_CORA, S_CORB: begin
          started_q <= !cor_done;
          if (cor_done) begin
            if (seq_q == S_CORA) begin
              ca_q <= cor_cos; sa_q <= cor_sin; seq_q <= S_CORB;
            end else begin
              cb_q <= cor_cos; sb_q <= cor_sin; seq_q <= S_MULM;
            end
          end
        end
        S_MULM: begin mini_q <= 48'(shifted); seq_q <= S_MULY; end
        S_MULY: begin py_q <= sat16(shifted); seq_q <= S_MULX; end
        S_MULX: begin px_q <= sat16(shifted); seq_q <= S_MULZ; end
        S_MULZ: begin pz_q <= sat16(shifted); seq_q <= S_OUT; end
        S_OUT: begin ov_q <= 1'b1; seq_q <= S_IDLE; end
        default: seq_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = ov_q;
  assign item_kind_o = kind_q;
  assign pos_x_o = px_q;
  assign pos_y_o = py_q;
  assign pos_z_o = pz_q;
  assign shade_r_o = or_q;
  assign shade_g_o = og_q;
  assign corner_a_o = a_q;
  assign corner_b_o = b_q;
  assign corner_c_o = c_q;
  assign last_o = last_q;

  a_busy_when_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("output pending while ready");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("output dropped");
  a_tri_no_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_kind_o |-> pos_x_o == 16'sd0 && shade_r_o == 16'd0)
    else $error("triangle with position");
  a_vtx_no_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !item_kind_o |-> !last_o) else $error("vertex flagged last");

endmodule
